// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked concurrent checks, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define DFFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every edge, reset included
`define DFFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/dffp_pkg.sv
// ----------------------------------------------------------------------------
// dffp_pkg
// Types, constants and the CRC-16/CCITT byte step for the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none
package dffp_pkg;

    localparam int MaxPayload = 64;
    localparam int PayAw      = $clog2(MaxPayload);
    localparam int LenW       = $clog2(MaxPayload + 1);

    localparam logic [7:0]  Magic0   = 8'hA5;
    localparam logic [7:0]  Magic1   = 8'h4E;
    localparam logic [7:0]  Version  = 8'h02;
    localparam logic [7:0]  Dollar   = 8'h24;
    localparam logic [7:0]  CharCr   = 8'h0D;
    localparam logic [7:0]  CharLf   = 8'h0A;
    localparam logic [15:0] CrcPoly  = 16'h1021;

    localparam logic [0:0] FmtBinary = 1'b0;
    localparam logic [0:0] FmtText   = 1'b1;
    localparam logic [0:0] CmdByte   = 1'b0;

    typedef enum logic [2:0] {
        PH_SEEK, PH_MAGIC1, PH_HEADER, PH_PAYLOAD, PH_CRCLO, PH_CRCHI, PH_TEXT
    } t_phase;

    typedef enum logic [2:0] {
        ST_BYTE = 3'd0, ST_CRC = 3'd1, ST_LEN = 3'd2, ST_OVF = 3'd3, ST_TMO = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0, CFG_CRC_INIT = 2'd1, CFG_TEXT_TYPE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {B_IDLE, B_READ, B_SHOW} t_bstate;

    // one entry of the front-to-back queue: a whole frame or one error
    typedef struct packed {
        t_status          status;
        logic             fmt;
        logic [7:0]       msg_type;
        logic [7:0]       msg_flags;
        logic [15:0]      seq;
        logic [LenW-1:0]  len;
    } t_job;

    typedef struct packed {
        logic             en;
        logic [PayAw-1:0] addr;
        logic [7:0]       data;
    } t_mem_wr;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dffp_front.sv
// ----------------------------------------------------------------------------
// dffp_front
// Accept words, check the gap timeout, parse both formats, queue jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module dffp_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_cmd,
    input  wire logic [7:0]            i_byte,
    input  wire logic [31:0]           i_now,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_addr,
    input  wire logic [31:0]           i_cfg_wdata,
    input  wire logic                  i_q_full,
    input  wire logic                  i_frame_done,
    output logic                       o_push,
    output dffp_pkg::t_job             o_job,
    output dffp_pkg::t_mem_wr          o_mem_wr,
    output logic                       o_frame_busy
);

    logic [31:0]                 r_timeout;
    logic [15:0]                 r_crc_init;
    logic [7:0]                  r_text_type;
    dffp_pkg::t_phase            r_phase, n_phase;
    logic                        r_active, n_active;
    logic                        r_busy, n_busy;
    logic [31:0]                 r_last, n_last;
    logic [2:0]                  r_hdr_cnt, n_hdr_cnt;
    logic [7:0]                  r_hdr [7];
    logic [7:0]                  n_hdr [7];
    logic [dffp_pkg::LenW-1:0]   r_pay_cnt, n_pay_cnt;
    logic [7:0]                  r_crc_lo, n_crc_lo;
    logic [15:0]                 r_crc, n_crc;

    logic             w_acc;
    logic             w_tmo;
    logic [31:0]      w_gap;
    dffp_pkg::t_phase w_base;
    logic [15:0]      w_hdr_len;
    logic [15:0]      w_pay_len;
    logic [15:0]      w_crc_step;

    assign o_ready      = !i_q_full && !r_busy;
    assign o_frame_busy = r_busy;
    assign w_acc        = i_valid && o_ready;
    assign w_gap        = i_now - r_last;
    assign w_tmo        = r_active && (w_gap > r_timeout);
    assign w_base       = w_tmo ? dffp_pkg::PH_SEEK : r_phase;
    assign w_hdr_len    = {i_byte, r_hdr[5]};
    assign w_pay_len    = {r_hdr[6], r_hdr[5]};
    assign w_crc_step   = dffp_pkg::crc_byte(r_crc, i_byte);

    always_comb begin
        n_phase   = r_phase;
        n_active  = r_active;
        n_busy    = r_busy;
        n_last    = r_last;
        n_hdr_cnt = r_hdr_cnt;
        n_hdr     = r_hdr;
        n_pay_cnt = r_pay_cnt;
        n_crc_lo  = r_crc_lo;
        n_crc     = r_crc;
        o_push    = 1'b0;
        o_job     = '0;
        o_mem_wr  = '0;
        if (i_frame_done) begin
            n_busy = 1'b0;
        end
        if (w_acc) begin
            if (w_tmo) begin
                o_push       = 1'b1;
                o_job.status = dffp_pkg::ST_TMO;
                o_job.fmt    = (r_phase == dffp_pkg::PH_TEXT);
                n_phase      = dffp_pkg::PH_SEEK;
                n_active     = 1'b0;
            end
            if (i_cmd == dffp_pkg::CmdByte) begin
                n_last = i_now;
                unique case (w_base)
                    dffp_pkg::PH_SEEK, dffp_pkg::PH_MAGIC1: begin
                        if (i_byte == dffp_pkg::Dollar) begin
                            n_phase   = dffp_pkg::PH_TEXT;
                            n_active  = 1'b1;
                            n_pay_cnt = '0;
                        end else if (i_byte == dffp_pkg::Magic0) begin
                            n_phase  = dffp_pkg::PH_MAGIC1;
                            n_active = 1'b1;
                        end else if (w_base == dffp_pkg::PH_MAGIC1 &&
                                     i_byte == dffp_pkg::Magic1) begin
                            n_phase   = dffp_pkg::PH_HEADER;
                            n_active  = 1'b1;
                            n_hdr_cnt = '0;
                            n_pay_cnt = '0;
                            n_crc     = r_crc_init;
                        end else begin
                            n_phase  = dffp_pkg::PH_SEEK;
                            n_active = 1'b0;
                        end
                    end
                    dffp_pkg::PH_TEXT: begin
                        if (i_byte == dffp_pkg::Dollar) begin
                            n_pay_cnt = '0;
                        end else if (i_byte == dffp_pkg::CharCr ||
                                     i_byte == dffp_pkg::CharLf) begin
                            n_phase  = dffp_pkg::PH_SEEK;
                            n_active = 1'b0;
                            if (r_pay_cnt != '0) begin
                                o_push         = 1'b1;
                                o_job.status   = dffp_pkg::ST_BYTE;
                                o_job.fmt      = dffp_pkg::FmtText;
                                o_job.msg_type = r_text_type;
                                o_job.len      = r_pay_cnt;
                                n_busy         = 1'b1;
                            end
                        end else if (r_pay_cnt >= dffp_pkg::LenW'(dffp_pkg::MaxPayload)) begin
                            o_push       = 1'b1;
                            o_job.status = dffp_pkg::ST_OVF;
                            o_job.fmt    = dffp_pkg::FmtText;
                            n_phase      = dffp_pkg::PH_SEEK;
                            n_active     = 1'b0;
                        end else begin
                            o_mem_wr.en   = 1'b1;
                            o_mem_wr.addr = r_pay_cnt[dffp_pkg::PayAw-1:0];
                            o_mem_wr.data = i_byte;
                            n_pay_cnt     = r_pay_cnt + 1'b1;
                        end
                    end
                    dffp_pkg::PH_HEADER: begin
                        n_hdr[r_hdr_cnt] = i_byte;
                        n_hdr_cnt        = r_hdr_cnt + 1'b1;
                        n_crc            = w_crc_step;
                        if (r_hdr_cnt == 3'd6) begin
                            if (r_hdr[0] != dffp_pkg::Version) begin
                                n_phase  = dffp_pkg::PH_SEEK;
                                n_active = 1'b0;
                            end else if (w_hdr_len > 16'(dffp_pkg::MaxPayload)) begin
                                o_push       = 1'b1;
                                o_job.status = dffp_pkg::ST_LEN;
                                o_job.fmt    = dffp_pkg::FmtBinary;
                                n_phase      = dffp_pkg::PH_SEEK;
                                n_active     = 1'b0;
                            end else if (w_hdr_len == '0) begin
                                n_phase = dffp_pkg::PH_CRCLO;
                            end else begin
                                n_phase = dffp_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    dffp_pkg::PH_PAYLOAD: begin
                        o_mem_wr.en   = 1'b1;
                        o_mem_wr.addr = r_pay_cnt[dffp_pkg::PayAw-1:0];
                        o_mem_wr.data = i_byte;
                        n_pay_cnt     = r_pay_cnt + 1'b1;
                        n_crc         = w_crc_step;
                        if (16'(n_pay_cnt) >= w_pay_len) begin
                            n_phase = dffp_pkg::PH_CRCLO;
                        end
                    end
                    dffp_pkg::PH_CRCLO: begin
                        n_crc_lo = i_byte;
                        n_phase  = dffp_pkg::PH_CRCHI;
                    end
                    dffp_pkg::PH_CRCHI: begin
                        o_push   = 1'b1;
                        n_phase  = dffp_pkg::PH_SEEK;
                        n_active = 1'b0;
                        o_job.fmt = dffp_pkg::FmtBinary;
                        if ({i_byte, r_crc_lo} != r_crc) begin
                            o_job.status = dffp_pkg::ST_CRC;
                        end else begin
                            o_job.status    = dffp_pkg::ST_BYTE;
                            o_job.msg_type  = r_hdr[1];
                            o_job.msg_flags = r_hdr[2];
                            o_job.seq       = {r_hdr[4], r_hdr[3]};
                            o_job.len       = r_pay_cnt;
                            n_busy          = 1'b1;
                        end
                    end
                    default: begin
                        n_phase  = dffp_pkg::PH_SEEK;
                        n_active = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dffp_pkg::PH_SEEK;
            r_active    <= 1'b0;
            r_busy      <= 1'b0;
            r_hdr_cnt   <= '0;
            r_pay_cnt   <= '0;
            r_timeout   <= 32'd100;
            r_crc_init  <= 16'hFFFF;
            r_text_type <= 8'h00;
        end else begin
            r_phase   <= n_phase;
            r_active  <= n_active;
            r_busy    <= n_busy;
            r_hdr_cnt <= n_hdr_cnt;
            r_pay_cnt <= n_pay_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    dffp_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_wdata;
                    dffp_pkg::CFG_CRC_INIT:  r_crc_init  <= i_cfg_wdata[15:0];
                    dffp_pkg::CFG_TEXT_TYPE: r_text_type <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        r_last   <= n_last;
        r_hdr    <= n_hdr;
        r_crc_lo <= n_crc_lo;
        r_crc    <= n_crc;
    end

endmodule
`default_nettype wire

// File: rtl/dffp_fifo.sv
// ----------------------------------------------------------------------------
// dffp_fifo
// Two-entry job queue between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none
module dffp_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  dffp_pkg::t_job      i_job,
    input  wire logic           i_pop,
    output dffp_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_full
);

    dffp_pkg::t_job r_mem [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_count;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dffp_back.sv
// ----------------------------------------------------------------------------
// dffp_back
// Hold the payload buffer; pop jobs and play them out as result words.
// ----------------------------------------------------------------------------
`default_nettype none
module dffp_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  dffp_pkg::t_mem_wr          i_mem_wr,
    input  wire logic                  i_q_empty,
    input  dffp_pkg::t_job             i_q_job,
    output logic                       o_pop,
    output logic                       o_frame_done,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output dffp_pkg::t_job             o_job,
    output logic [dffp_pkg::PayAw-1:0] o_index,
    output logic [7:0]                 o_byte,
    output logic                       o_byte_valid,
    output logic                       o_last
);

    logic [7:0]                  r_mem [dffp_pkg::MaxPayload];
    dffp_pkg::t_bstate           r_state, n_state;
    dffp_pkg::t_job              r_job, n_job;
    logic [dffp_pkg::PayAw-1:0]  r_idx, n_idx;
    logic                        r_bvalid, n_bvalid;
    logic [7:0]                  r_rd_data;
    logic [dffp_pkg::LenW-1:0]   w_next_cnt;

    assign w_next_cnt   = {1'b0, r_idx} + 1'b1;
    assign o_valid      = (r_state == dffp_pkg::B_SHOW);
    assign o_job        = r_job;
    assign o_index      = r_idx;
    assign o_byte_valid = r_bvalid;
    assign o_byte       = r_bvalid ? r_rd_data : 8'h00;
    assign o_last       = !r_bvalid || (w_next_cnt == r_job.len);

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_idx        = r_idx;
        n_bvalid     = r_bvalid;
        o_pop        = 1'b0;
        o_frame_done = 1'b0;
        unique case (r_state)
            dffp_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_job = i_q_job;
                    n_idx = '0;
                    if (i_q_job.status == dffp_pkg::ST_BYTE && i_q_job.len != '0) begin
                        n_bvalid = 1'b1;
                        n_state  = dffp_pkg::B_READ;
                    end else begin
                        n_bvalid = 1'b0;
                        n_state  = dffp_pkg::B_SHOW;
                    end
                end
            end
            dffp_pkg::B_READ: begin
                n_state = dffp_pkg::B_SHOW;
            end
            dffp_pkg::B_SHOW: begin
                if (i_ready) begin
                    if (!o_last) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = dffp_pkg::B_READ;
                    end else begin
                        n_state      = dffp_pkg::B_IDLE;
                        o_frame_done = (r_job.status == dffp_pkg::ST_BYTE);
                    end
                end
            end
            default: n_state = dffp_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dffp_pkg::B_IDLE;
            r_idx    <= '0;
            r_bvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_bvalid <= n_bvalid;
        end
        r_job <= n_job;
    end

    // payload buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        if (r_state == dffp_pkg::B_READ) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

endmodule
`default_nettype wire

// File: rtl/dual_format_frame_parser_top.sv
// ----------------------------------------------------------------------------
// dual_format_frame_parser_top
// UART deframer for binary (A5 4E, CRC-16/CCITT) and text ('$' line) frames.
// ----------------------------------------------------------------------------
// Input stream: one word per received byte (tuser = 0) or per poll tick
// (tuser = 1); tdata carries the byte and its millisecond timestamp.
// A free input word is taken while tready is high; the parser updates its state in
// that cycle and queues at most one job (a good frame or an error).
// Output stream: a good frame plays out as one word per payload byte, tlast
// on the final one; an empty binary frame gives one word with byte_valid 0.
// Each error (crc, length, overflow, timeout) gives one word with tlast set.
// Result path: the closing input word queues the job; the emitter pops it
// when idle, then reads each payload byte and shows it (buffer read, then
// show) through the single registered read port of the 64-byte payload buffer.
// While a frame plays out, input is held off (tready low) since the buffer
// is reused by the next frame. Error jobs queue up to two deep behind a
// stalled receiver; a full queue holds off input as well.
// A stalled receiver holds the current result word; nothing is dropped.
// Reset (synchronous, active low) returns to magic search, empties the
// queue and loads timeout 100 ms, crc_init FFFF and text type 0.
// Configuration writes take effect in the cycle after the write; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dual_format_frame_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // rx_byte[7:0], now_ms[39:8]
    input  wire logic        s_axis_tuser,   // cmd[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // msg_type[7:0], msg_flags[15:8],
                                             // sequence_res[31:16], payload_len[38:32],
                                             // byte_index[44:39], payload_byte[52:45],
                                             // byte_valid[53], zero[55:54]
    output logic [3:0]       m_axis_tuser,   // status[2:0], format[3]
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    dffp_pkg::t_job              w_push_job, w_q_job, w_out_job;
    dffp_pkg::t_mem_wr           w_mem_wr;
    logic                        w_push, w_pop, w_q_empty, w_q_full;
    logic                        w_frame_done, w_frame_busy;
    logic [dffp_pkg::PayAw-1:0]  w_index;
    logic [7:0]                  w_byte;
    logic                        w_byte_valid;

    // parse side
    dffp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_byte       (s_axis_tdata[7:0]),
        .i_now        (s_axis_tdata[39:8]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_full     (w_q_full),
        .i_frame_done (w_frame_done),
        .o_push       (w_push),
        .o_job        (w_push_job),
        .o_mem_wr     (w_mem_wr),
        .o_frame_busy (w_frame_busy)
    );

    dffp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_q_job),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // emit side
    dffp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mem_wr     (w_mem_wr),
        .i_q_empty    (w_q_empty),
        .i_q_job      (w_q_job),
        .o_pop        (w_pop),
        .o_frame_done (w_frame_done),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_job        (w_out_job),
        .o_index      (w_index),
        .o_byte       (w_byte),
        .o_byte_valid (w_byte_valid),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_byte_valid, w_byte, w_index, w_out_job.len,
                           w_out_job.seq, w_out_job.msg_flags, w_out_job.msg_type};
    assign m_axis_tuser = {w_out_job.fmt, w_out_job.status};

    // no push into a full queue
    `DFFP_ASSERT(a_no_overflow, w_push |-> !w_q_full, "job queue overflow")
    // a frame done pulse only while the parser is held off for that frame
    `DFFP_ASSERT(a_done_busy, w_frame_done |-> w_frame_busy, "frame done without frame")
    // payload words stay inside the frame length
    `DFFP_ASSERT(a_idx_range, (m_axis_tvalid && w_byte_valid) |->
        ({1'b0, w_index} < w_out_job.len), "byte index past length")
    // nothing shown right after reset
    `DFFP_ASSERT_ALWAYS(a_reset_quiet, $past(!i_rst_n) |-> !m_axis_tvalid,
        "output valid after reset")

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dual_format_frame_parser_top. A directed table opens
// the run, then random binary and text frames, broken frames and noise run
// under several register settings. Every result word is checked against a
// behavioral predictor, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import dffp_pkg::*;

    // one expected result word
    typedef struct {
        t_status     status;
        logic        fmt;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [15:0] seq;
        logic [6:0]  len;
        logic [5:0]  idx;
        logic [7:0]  data;
        logic        valid;
        logic        last;
    } t_word_exp;

    // directed row: an input word, plus an error status where one is obvious
    typedef struct {
        logic        cmd;
        logic [7:0]  rx;
        logic [31:0] dt;
        logic        chk;
        t_status     err;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // rx_byte[7:0], now_ms[39:8]
    logic        s_axis_tuser;   // cmd[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // msg_type, msg_flags, sequence_res, payload_len,
                                 // byte_index, payload_byte, byte_valid, zero
    logic [3:0]  m_axis_tuser;   // status[2:0], format[3]
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;

    dual_format_frame_parser_top dut (.*);

    // ---- predictor state: register copies and parser state ----
    logic [31:0] cfg_tmo;
    logic [15:0] cfg_crc;
    logic [7:0]  cfg_type;
    t_phase      ph;
    logic        open_frame;
    logic [31:0] last_t;
    int          hcnt;
    logic [7:0]  hdr [7];
    logic [7:0]  pay [64];
    int          pcnt;
    logic [7:0]  crc_lo;
    logic [15:0] crc_run;
    t_status     last_status;

    t_word_exp   words_due[$];
    logic [31:0] now_ms;
    int          n_err;
    int          n_sent;
    int          n_words;
    int          n_frames;
    int          n_errwords;
    bit          quiet;
    bit          hold_req;

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) c = {c[14:0], 1'b0} ^ (c[15] ? CrcPoly : 16'h0000);
        return c;
    endfunction

    function void push_word(t_status st, logic fm, logic [7:0] ty, logic [7:0] fl,
                            logic [15:0] sq, logic [6:0] ln, logic [5:0] ix,
                            logic [7:0] d, logic v, logic l);
        t_word_exp w;
        w = '{st, fm, ty, fl, sq, ln, ix, d, v, l};
        words_due.push_back(w);
        last_status = st;
    endfunction

    function void drop_frame();
        ph = PH_SEEK;
        open_frame = 0;
        last_t = 0;
        hcnt = 0;
        foreach (hdr[k]) hdr[k] = 8'h00;
        pcnt = 0;
        crc_lo = 8'h00;
        crc_run = cfg_crc;
    endfunction

    function void open_at(t_phase p, logic [31:0] t);
        drop_frame();
        ph = p;
        last_t = t;
        open_frame = 1;
    endfunction

    function void flag_error(t_status st);
        push_word(st, ph == PH_TEXT, 8'h00, 8'h00, 16'h0, 7'd0, 6'd0, 8'h00, 1'b0, 1'b1);
        drop_frame();
    endfunction

    function void play_frame(logic fm, logic [7:0] ty, logic [7:0] fl, logic [15:0] sq);
        if (pcnt == 0) begin
            push_word(ST_BYTE, fm, ty, fl, sq, 7'd0, 6'd0, 8'h00, 1'b0, 1'b1);
        end else begin
            for (int k = 0; k < pcnt; k++)
                push_word(ST_BYTE, fm, ty, fl, sq, 7'(pcnt), 6'(k), pay[k], 1'b1,
                          k + 1 == pcnt);
        end
        n_frames++;
        drop_frame();
    endfunction

    // advance the parser by one accepted word and queue what it yields
    function void parse_byte_word(logic cmd, logic [7:0] b, logic [31:0] t);
        logic [31:0] gap;
        int          ln;
        gap = t - last_t;
        if (open_frame && gap > cfg_tmo) flag_error(ST_TMO);
        if (cmd != CmdByte) return;
        if ((ph == PH_SEEK || ph == PH_MAGIC1) && b == Dollar) begin
            open_at(PH_TEXT, t);
            return;
        end
        last_t = t;
        ln = {hdr[6], hdr[5]};
        case (ph)
            PH_SEEK: begin
                if (b == Magic0) begin
                    ph = PH_MAGIC1;
                    open_frame = 1;
                end
            end
            PH_MAGIC1: begin
                if (b == Magic1) begin
                    open_at(PH_HEADER, t);
                    crc_run = cfg_crc;
                end else if (b != Magic0) begin
                    drop_frame();
                end
            end
            PH_TEXT: begin
                if (b == Dollar) open_at(PH_TEXT, t);
                else if (b == CharCr || b == CharLf) begin
                    if (pcnt == 0) drop_frame();
                    else play_frame(FmtText, cfg_type, 8'h00, 16'h0);
                end else if (pcnt >= MaxPayload) flag_error(ST_OVF);
                else begin
                    pay[pcnt] = b;
                    pcnt++;
                end
            end
            PH_HEADER: begin
                hdr[hcnt] = b;
                hcnt++;
                crc_run = crc_step(crc_run, b);
                if (hcnt == 7) begin
                    ln = {hdr[6], hdr[5]};
                    if (hdr[0] != Version) drop_frame();
                    else if (ln > MaxPayload) flag_error(ST_LEN);
                    else ph = (ln == 0) ? PH_CRCLO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pay[pcnt] = b;
                pcnt++;
                crc_run = crc_step(crc_run, b);
                if (pcnt >= ln) ph = PH_CRCLO;
            end
            PH_CRCLO: begin
                crc_lo = b;
                ph = PH_CRCHI;
            end
            PH_CRCHI: begin
                if ({b, crc_lo} != crc_run) flag_error(ST_CRC);
                else play_frame(FmtBinary, hdr[1], hdr[2], {hdr[4], hdr[3]});
            end
            default: drop_frame();
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        n_err++;
    endtask

    // ---- clock, reset and the run limit ----
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $display("run limit reached with %0d words still due", words_due.size());
        $finish;
    end

    // ---- receiver: random stall per word, one long hold-off on request ----
    initial begin
        int stall;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (hold_req) begin
                stall = 400;
                hold_req = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // ---- result checker: compare each taken word with the oldest expectation ----
    always @(posedge i_clk) begin
        t_word_exp w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_words++;
            if (words_due.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[31:0], 0);
            end else begin
                w = words_due.pop_front();
                if (w.status != t_status'(m_axis_tuser[2:0]))
                    report_mismatch("status", m_axis_tuser[2:0], w.status);
                if (w.status != ST_BYTE) n_errwords++;
                if (w.fmt != m_axis_tuser[3])  report_mismatch("format", m_axis_tuser[3], w.fmt);
                if (w.msg_type != m_axis_tdata[7:0])
                    report_mismatch("msg_type", m_axis_tdata[7:0], w.msg_type);
                if (w.msg_flags != m_axis_tdata[15:8])
                    report_mismatch("msg_flags", m_axis_tdata[15:8], w.msg_flags);
                if (w.seq != m_axis_tdata[31:16])
                    report_mismatch("sequence", m_axis_tdata[31:16], w.seq);
                if (w.len != m_axis_tdata[38:32])
                    report_mismatch("payload_len", m_axis_tdata[38:32], w.len);
                if (w.idx != m_axis_tdata[44:39])
                    report_mismatch("byte_index", m_axis_tdata[44:39], w.idx);
                if (w.data != m_axis_tdata[52:45])
                    report_mismatch("payload_byte", m_axis_tdata[52:45], w.data);
                if (w.valid != m_axis_tdata[53])
                    report_mismatch("byte_valid", m_axis_tdata[53], w.valid);
                if (w.last != m_axis_tlast) report_mismatch("tlast", m_axis_tlast, w.last);
            end
        end
    end

    // ---- sender side ----

    // offer one word after a random gap; advance the clock stamp by dt first
    task automatic send_word(logic cmd, logic [7:0] b, logic [31:0] dt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        now_ms = now_ms + dt;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {now_ms, b};
        do @(posedge i_clk); while (!s_axis_tready);
        parse_byte_word(cmd, b, now_ms);
        n_sent++;
        @(negedge i_clk);
    endtask

    // wait for every result, then let the block settle before a register write
    task automatic drain();
        s_axis_tvalid <= 0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we    <= 1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_TIMEOUT:  cfg_tmo  = val;
            CFG_CRC_INIT: cfg_crc  = val[15:0];
            default:      cfg_type = val[7:0];
        endcase
    endtask

    // byte-to-byte stamp step: mostly small, now and then at or just past the timeout
    function automatic logic [31:0] pick_dt();
        if ($urandom_range(0, 39) == 0) return cfg_tmo + $urandom_range(0, 1);
        if (cfg_tmo == 0) return ($urandom_range(0, 9) == 0);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_binary(int len_sel);
        logic [7:0]  h [7];
        logic [7:0]  p [64];
        logic [15:0] c;
        int          ln;
        case (len_sel)
            0:       ln = 0;
            1:       ln = MaxPayload;
            2:       ln = $urandom_range(MaxPayload + 1, 65535);
            3:       ln = $urandom_range(7, 63);
            default: ln = $urandom_range(0, 6);
        endcase
        h[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : Version;
        for (int k = 1; k < 5; k++) h[k] = $urandom;
        h[5] = ln[7:0];
        h[6] = ln[15:8];
        c = cfg_crc;
        send_word(CmdByte, Magic0, pick_dt());
        send_word(CmdByte, Magic1, pick_dt());
        for (int k = 0; k < 7; k++) begin
            c = crc_step(c, h[k]);
            send_word(CmdByte, h[k], pick_dt());
        end
        if (h[0] != Version || ln > MaxPayload) return;
        for (int k = 0; k < ln; k++) begin
            p[k] = ($urandom_range(0, 15) == 0) ? Dollar : 8'($urandom);
            c = crc_step(c, p[k]);
            send_word(CmdByte, p[k], pick_dt());
        end
        // corrupt the check now and then
        if ($urandom_range(0, 6) == 0) c = c ^ 16'(1 << $urandom_range(0, 15));
        send_word(CmdByte, c[7:0], pick_dt());
        send_word(CmdByte, c[15:8], pick_dt());
    endtask

    task automatic send_text(int len_sel);
        logic [7:0] b;
        int         ln;
        ln = (len_sel == 1) ? $urandom_range(MaxPayload, MaxPayload + 2)
                            : $urandom_range(0, 8);
        send_word(CmdByte, Dollar, pick_dt());
        for (int k = 0; k < ln; k++) begin
            do b = $urandom; while (b == Dollar || b == CharCr || b == CharLf);
            send_word(CmdByte, b, pick_dt());
        end
        send_word(CmdByte, $urandom_range(0, 1) ? CharCr : CharLf, pick_dt());
    endtask

    // line noise: stray bytes, magic fragments and poll ticks
    task automatic send_noise();
        int n;
        int r;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 5);
            if (r == 0)      send_word(1'b1, 8'($urandom), $urandom_range(0, 200));
            else if (r == 1) send_word(CmdByte, Magic0, pick_dt());
            else if (r == 2) send_word(CmdByte, Dollar, pick_dt());
            else             send_word(CmdByte, 8'($urandom), pick_dt());
        end
    endtask

    task automatic run_random(int n_items);
        int stop;
        int r;
        stop = n_sent + n_items;
        while (n_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 45)      send_binary($urandom_range(0, 9));
            else if (r < 75) send_text($urandom_range(0, 7));
            else             send_noise();
        end
    endtask

    // directed opening: poll, text frames, timeout, bad version, length error
    t_row rows [] = '{
        '{1'b1, 8'hFF, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, Dollar, 32'd0,  1'b0, ST_BYTE},
        '{1'b0, 8'hFF, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd1,   1'b0, ST_BYTE},
        '{1'b0, CharCr, 32'd1,  1'b0, ST_BYTE},
        '{1'b0, Dollar, 32'd2,  1'b0, ST_BYTE},
        '{1'b0, CharLf, 32'd2,  1'b0, ST_BYTE},
        '{1'b0, Dollar, 32'd0,  1'b0, ST_BYTE},
        '{1'b0, 8'h41, 32'd5,   1'b0, ST_BYTE},
        '{1'b1, 8'h00, 32'd101, 1'b1, ST_TMO},
        '{1'b0, Magic0, 32'd3,  1'b0, ST_BYTE},
        '{1'b0, Magic1, 32'd0,  1'b0, ST_BYTE},
        '{1'b0, 8'h01, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, Magic0, 32'd0,  1'b0, ST_BYTE},
        '{1'b0, Magic1, 32'd0,  1'b0, ST_BYTE},
        '{1'b0, Version, 32'd0, 1'b0, ST_BYTE},
        '{1'b0, 8'h7E, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h81, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h34, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h12, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h41, 32'd0,   1'b0, ST_BYTE},
        '{1'b0, 8'h00, 32'd0,   1'b1, ST_LEN}
    };

    // ---- main sequence ----
    initial begin
        s_axis_tvalid = 0;
        s_axis_tuser  = 0;
        s_axis_tdata  = '0;
        i_cfg_we      = 0;
        i_cfg_addr    = CFG_TIMEOUT;
        i_cfg_wdata   = '0;
        i_rst_n       = 0;
        quiet         = 0;
        hold_req      = 0;
        n_err         = 0;
        n_sent        = 0;
        n_words       = 0;
        n_frames      = 0;
        n_errwords    = 0;
        // stamps start just below the wrap so the first frames cross it
        now_ms        = 32'hFFFF_FFF0;
        cfg_tmo       = 100;
        cfg_crc       = 16'hFFFF;
        cfg_type      = 8'h00;
        drop_frame();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed table at reset defaults; obvious errors are typed in
        foreach (rows[k]) begin
            send_word(rows[k].cmd, rows[k].rx, rows[k].dt);
            if (rows[k].chk && last_status != rows[k].err)
                report_mismatch("directed row status", last_status, rows[k].err);
        end
        send_binary(0);
        send_binary(1);
        send_text(1);
        drain();

        // defaults, with one long receiver hold-off behind a full-size frame
        hold_req = 1;
        send_binary(1);
        run_random(40);
        drain();

        // widest timeout, zero seed, top text type; no idling for a while
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_CRC_INIT, 16'h0000);
        write_reg(CFG_TEXT_TYPE, 8'hFF);
        quiet = 1;
        run_random(25);
        quiet = 0;
        run_random(25);
        drain();

        // zero timeout: any stamp gap inside a frame aborts it
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_CRC_INIT, 16'h1D0F);
        write_reg(CFG_TEXT_TYPE, 8'h5A);
        run_random(30);
        drain();

        // random mid-range settings
        write_reg(CFG_TIMEOUT, $urandom_range(2, 5000));
        write_reg(CFG_CRC_INIT, $urandom_range(0, 65535));
        write_reg(CFG_TEXT_TYPE, $urandom_range(0, 255));
        run_random(30);
        drain();
        repeat (30) @(negedge i_clk);

        $display("Sent %0d input words over four register settings.", n_sent);
        $display("Checked %0d result words: %0d good frames, %0d error words.",
                 n_words, n_frames, n_errwords);
        if (n_err == 0 && words_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
